### design/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge outside reset.
`define CSQ_ASSERT_ALWAYS(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) else $error(msg);

// When the trigger holds, the consequence must hold in the next cycle.
`define CSQ_ASSERT_NEXT(lbl, clk, rstn, trig, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (trig) |=> (cons)) else $error(msg);

`endif

### design/csq_pkg.sv
`default_nettype none

package csq_pkg;

    // Sizes of the semaphore.
    localparam int QUEUE_DEPTH = 8;
    localparam int UNIT_BITS   = 16;
    localparam int ID_BITS     = 4;
    localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Request types.
    localparam logic REQ_OBTAIN  = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    // Result outcome codes.
    localparam logic [1:0] OC_GRANT  = 2'd0;
    localparam logic [1:0] OC_REFUSE = 2'd1;
    localparam logic [1:0] OC_FULL   = 2'd2;

    // Configuration register indexes.
    localparam int         CFG_IDX_W      = 1;
    localparam int         CFG_DATA_W     = 16;
    localparam logic [0:0] CFG_FIFO_MODE  = 1'd0;
    localparam logic [0:0] CFG_INIT_UNITS = 1'd1;

    // Input item.
    typedef struct packed {
        logic                 req_type;
        logic [ID_BITS-1:0]   requester_id;
        logic [UNIT_BITS-1:0] amount;
        logic                 wait_if_short;
    } t_in_s;

    // Result item.
    typedef struct packed {
        logic [ID_BITS-1:0]   grant_id;
        logic [1:0]           outcome;
        logic [UNIT_BITS-1:0] units_left;
        logic                 last;
    } t_out_s;

    // One waiting-queue entry.
    typedef struct packed {
        logic [ID_BITS-1:0]   id;
        logic [UNIT_BITS-1:0] amount;
    } t_qent_s;

    // Control from the sequencer to the result buffer.
    typedef struct packed {
        logic load;
        logic push;
        logic push_last;
    } t_rb_ctl_s;

    // Status from the result buffer to the sequencer.
    typedef struct packed {
        logic pend_vld;
        logic can_push;
    } t_rb_sts_s;

endpackage

`default_nettype wire

### design/csq_queue_ram.sv
`default_nettype none

module csq_queue_ram
    import csq_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [IDX_W-1:0] i_waddr,
    input  wire t_qent_s          i_wdata,
    input  wire logic             i_re,
    input  wire logic [IDX_W-1:0] i_raddr,
    output t_qent_s               o_rdata
);

    t_qent_s r_mem [QUEUE_DEPTH];
    t_qent_s r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port; the data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### design/csq_result_buf.sv
`default_nettype none

module csq_result_buf
    import csq_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_rb_ctl_s i_ctl,
    input  wire t_out_s    i_data,
    output t_rb_sts_s      o_sts,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_s         o_out_data
);

    t_out_s r_pend;
    logic   r_pend_vld;
    t_out_s r_out;
    logic   r_out_vld;

    // The pending result waits until it is known whether another follows it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_vld <= 1'b0;
        end else if (i_ctl.load) begin
            r_pend_vld <= 1'b1;
        end else if (i_ctl.push) begin
            r_pend_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_pend <= i_data;
        end
    end

    // Output register, refilled from the pending slot.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_ctl.push) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_out <= '{grant_id: r_pend.grant_id, outcome: r_pend.outcome,
                       units_left: r_pend.units_left, last: i_ctl.push_last};
        end
    end

    assign o_sts.pend_vld = r_pend_vld;
    assign o_sts.can_push = !r_out_vld || i_out_ready;
    assign o_out_valid    = r_out_vld;
    assign o_out_data     = r_out;

endmodule

`default_nettype wire

### design/chunk_semaphore_wait_queue_top.sv
// Obtain: result via pending slot and output register; a queued obtain keeps the input ready.
// Release: scan of N queued waiters, one queue-RAM read per cycle; output stalls hold the scan.
// Throughput: one item at a time; the queue scan over the single-port read RAM sets the rate.
// Reset (synchronous, active low): 0 units, empty queue, FIFO mode on; queue RAM not cleared.
`default_nettype none
`include "assert_macros.svh"

module chunk_semaphore_wait_queue_top
    import csq_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_in_s                 i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_out_s                     o_out_data
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    logic [1:0]           r_state, n_state;
    logic [UNIT_BITS-1:0] r_avail, n_avail;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [CNT_W-1:0]     r_ev, n_ev;
    logic [CNT_W-1:0]     r_wr, n_wr;
    logic                 r_stop, n_stop;
    logic                 r_fifo, n_fifo;

    logic                 w_in_acc;
    logic                 w_adv;
    logic                 w_grant;
    logic                 w_scan_last;
    logic [CNT_W-1:0]     w_ev_nxt;
    logic [UNIT_BITS:0]   w_sum;
    logic [UNIT_BITS-1:0] w_sub_in;
    logic [UNIT_BITS-1:0] w_sub_q;

    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    t_qent_s              mem_wdata;
    logic                 mem_re;
    logic [IDX_W-1:0]     mem_raddr;
    t_qent_s              q_rdata;

    t_rb_ctl_s            rb_ctl;
    t_rb_sts_s            rb_sts;
    t_out_s               rb_data;

    csq_queue_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (q_rdata)
    );

    csq_result_buf u_rbuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (rb_ctl),
        .i_data      (rb_data),
        .o_sts       (rb_sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;

    // Arithmetic on the unit count.
    assign w_sum       = {1'b0, r_avail} + {1'b0, i_in_data.amount};
    assign w_sub_in    = r_avail - i_in_data.amount;
    assign w_sub_q     = r_avail - q_rdata.amount;
    assign w_ev_nxt    = r_ev + CNT_W'(1);
    assign w_scan_last = (w_ev_nxt == r_count);
    assign w_grant     = !r_stop && (r_avail >= q_rdata.amount);

    // Sequencer: config writes, request decode, queue scan with in-place compaction, flush.
    always_comb begin
        n_state   = r_state;
        n_avail   = r_avail;
        n_count   = r_count;
        n_ev      = r_ev;
        n_wr      = r_wr;
        n_stop    = r_stop;
        n_fifo    = r_fifo;
        w_adv     = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = r_count[IDX_W-1:0];
        mem_wdata = '{id: i_in_data.requester_id, amount: i_in_data.amount};
        mem_re    = 1'b0;
        mem_raddr = '0;
        rb_ctl    = '0;
        rb_data   = '{grant_id: i_in_data.requester_id, outcome: OC_GRANT,
                      units_left: w_sub_in, last: 1'b0};

        case (r_state)
            S_IDLE: begin
                if (i_cfg_we) begin
                    case (i_cfg_idx)
                        CFG_FIFO_MODE:  n_fifo  = i_cfg_data[0];
                        CFG_INIT_UNITS: n_avail = i_cfg_data[UNIT_BITS-1:0];
                        default:        n_fifo  = r_fifo;
                    endcase
                end
                if (w_in_acc) begin
                    if (i_in_data.req_type == REQ_OBTAIN) begin
                        if (!(r_fifo && (r_count != '0)) && (r_avail >= i_in_data.amount)) begin
                            n_avail     = w_sub_in;
                            rb_ctl.load = 1'b1;
                            n_state     = S_FINISH;
                        end else if (i_in_data.wait_if_short) begin
                            if (r_count < CNT_W'(QUEUE_DEPTH)) begin
                                mem_we  = 1'b1;
                                n_count = r_count + CNT_W'(1);
                            end else begin
                                rb_data.outcome    = OC_FULL;
                                rb_data.units_left = r_avail;
                                rb_ctl.load        = 1'b1;
                                n_state            = S_FINISH;
                            end
                        end else begin
                            rb_data.outcome    = OC_REFUSE;
                            rb_data.units_left = r_avail;
                            rb_ctl.load        = 1'b1;
                            n_state            = S_FINISH;
                        end
                    end else begin
                        // Release: saturating add, then scan from the oldest waiter.
                        n_avail = w_sum[UNIT_BITS] ? '1 : w_sum[UNIT_BITS-1:0];
                        n_ev    = '0;
                        n_wr    = '0;
                        n_stop  = 1'b0;
                        if (r_count == '0) begin
                            n_state = S_FINISH;
                        end else begin
                            mem_re  = 1'b1;
                            n_state = S_SCAN;
                        end
                    end
                end
            end

            S_SCAN: begin
                if (w_grant) begin
                    // A grant needs the pending slot; an earlier grant moves out first.
                    if (!rb_sts.pend_vld || rb_sts.can_push) begin
                        n_avail            = w_sub_q;
                        rb_data.grant_id   = q_rdata.id;
                        rb_data.units_left = w_sub_q;
                        rb_ctl.load        = 1'b1;
                        rb_ctl.push        = rb_sts.pend_vld;
                        w_adv              = 1'b1;
                    end
                end else begin
                    // Kept waiter is written back at the compacted position.
                    mem_we    = 1'b1;
                    mem_waddr = r_wr[IDX_W-1:0];
                    mem_wdata = q_rdata;
                    n_wr      = r_wr + CNT_W'(1);
                    if (r_fifo) begin
                        n_stop = 1'b1;
                    end
                    w_adv = 1'b1;
                end
                if (w_adv) begin
                    if (w_scan_last) begin
                        n_count = w_grant ? r_wr : (r_wr + CNT_W'(1));
                        n_state = S_FINISH;
                    end else begin
                        mem_re    = 1'b1;
                        mem_raddr = w_ev_nxt[IDX_W-1:0];
                        n_ev      = w_ev_nxt;
                    end
                end
            end

            S_FINISH: begin
                // The last result of this item leaves with its end mark.
                if (!rb_sts.pend_vld) begin
                    n_state = S_IDLE;
                end else if (rb_sts.can_push) begin
                    rb_ctl.push      = 1'b1;
                    rb_ctl.push_last = 1'b1;
                    n_state          = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_avail <= '0;
            r_count <= '0;
            r_ev    <= '0;
            r_wr    <= '0;
            r_stop  <= 1'b0;
            r_fifo  <= 1'b1;
        end else begin
            r_state <= n_state;
            r_avail <= n_avail;
            r_count <= n_count;
            r_ev    <= n_ev;
            r_wr    <= n_wr;
            r_stop  <= n_stop;
            r_fifo  <= n_fifo;
        end
    end

    // Checks on the sequencer.
    `CSQ_ASSERT_ALWAYS(a_count_range, i_clk, i_rst_n, r_count <= CNT_W'(QUEUE_DEPTH), "queue count overflow")
    `CSQ_ASSERT_ALWAYS(a_idle_flushed, i_clk, i_rst_n, (r_state != S_IDLE) || !rb_sts.pend_vld, "pending result left in idle")
    `CSQ_ASSERT_ALWAYS(a_compact_order, i_clk, i_rst_n, (r_state != S_SCAN) || (r_wr <= r_ev), "write index passed read index")
    `CSQ_ASSERT_NEXT(a_scan_start, i_clk, i_rst_n, w_in_acc && (i_in_data.req_type == REQ_RELEASE) && (r_count != '0), r_state == S_SCAN, "release with waiters did not scan")

endmodule

`default_nettype wire
